### rtl/core/ptb_pkg.sv
// ptb_pkg: shared types and constants for the periodic timer bank
// used by the channel interfaces, the timer cell and the top level
`timescale 1ns / 1ps

package ptb_pkg;

   localparam int OP_W     = 3;
   localparam int IDX_W    = 8;
   localparam int NOW_W    = 32;
   localparam int PERIOD_W = 32;
   localparam int MASK_W   = 8;

   localparam logic [OP_W-1:0] OP_SCAN    = 3'd0;
   localparam logic [OP_W-1:0] OP_BEGIN   = 3'd1;
   localparam logic [OP_W-1:0] OP_RESTAMP = 3'd2;
   localparam logic [OP_W-1:0] OP_HALT    = 3'd3;
   localparam logic [OP_W-1:0] OP_RESUME  = 3'd4;

   // command and partial result handed from cell to cell
   typedef struct packed {
      logic                valid;
      logic [OP_W-1:0]     opcode;
      logic [IDX_W-1:0]    timer_index;
      logic [PERIOD_W-1:0] period_ms;
      logic                handler_present;
      logic                start_now;
      logic                accepted;
      logic [MASK_W-1:0]   fired_mask;
      logic [MASK_W-1:0]   active_mask;
   } cmd_type;

endpackage

### rtl/core/ptb_ifs.sv
// ptb_req_if and ptb_rsp_if: valid/ready channels of the periodic timer bank
// depends on ptb_pkg
`timescale 1ns / 1ps

interface ptb_req_if;
   import ptb_pkg::*;

   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     opcode;
   logic [IDX_W-1:0]    timer_index;
   logic [NOW_W-1:0]    now_ms;
   logic [PERIOD_W-1:0] period_ms;
   logic                handler_present;
   logic                start_now;

   modport source (
      output valid, opcode, timer_index, now_ms, period_ms, handler_present, start_now,
      input  ready
   );
   modport sink (
      input  valid, opcode, timer_index, now_ms, period_ms, handler_present, start_now,
      output ready
   );
endinterface

interface ptb_rsp_if;
   import ptb_pkg::*;

   logic              valid;
   logic              ready;
   logic [MASK_W-1:0] fired_mask;
   logic [MASK_W-1:0] active_mask;
   logic              accepted;

   modport source (
      output valid, fired_mask, active_mask, accepted,
      input  ready
   );
   modport sink (
      input  valid, fired_mask, active_mask, accepted,
      output ready
   );
endinterface

### rtl/core/ptb_cell.sv
// ptb_cell: one timer of the bank, applies the passing item to its own state
// and hands the item with its partial masks to the next cell; uses ptb_pkg
`timescale 1ns / 1ps

module ptb_cell #(
   parameter int TIME_BITS  = 32,
   parameter int CELL_INDEX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   stall,
   input  ptb_pkg::cmd_type       cmd_in,
   input  logic [TIME_BITS-1:0]   now_in,
   output ptb_pkg::cmd_type       cmd_out,
   output logic [TIME_BITS-1:0]   now_out
);
   import ptb_pkg::*;

   localparam int CMP_W = (TIME_BITS > PERIOD_W) ? TIME_BITS : PERIOD_W;
   localparam logic [MASK_W-1:0] CELL_BIT =
      (CELL_INDEX < MASK_W) ? (MASK_W'(1) << CELL_INDEX) : '0;

   logic [PERIOD_W-1:0]  period_ff, period_in;
   logic [TIME_BITS-1:0] stamp_ff, stamp_in;
   logic                 active_ff, active_in;
   logic                 start_ff, start_in;
   logic                 handler_ff, handler_in;
   cmd_type              cmd_ff, cmd_in_next;
   logic [TIME_BITS-1:0] now_ff;

   logic [TIME_BITS-1:0] elapsed;
   logic                 visit;
   logic                 hit;
   logic                 eligible;
   logic                 due;
   logic                 fire;

   always_comb begin
      elapsed  = now_in - stamp_ff;
      visit    = cmd_in.valid && !stall;
      hit      = (cmd_in.timer_index == IDX_W'(CELL_INDEX));
      eligible = (period_ff != '0) && handler_ff && active_ff;
      due      = (CMP_W'(elapsed) >= CMP_W'(period_ff)) || start_ff;

      period_in  = period_ff;
      stamp_in   = stamp_ff;
      active_in  = active_ff;
      start_in   = start_ff;
      handler_in = handler_ff;
      fire       = 1'b0;

      if (visit) begin
         unique case (cmd_in.opcode)
            OP_SCAN: begin
               if (eligible && due) begin
                  fire     = 1'b1;
                  stamp_in = now_in;
                  start_in = 1'b0;
               end
            end
            OP_BEGIN: begin
               if (hit) begin
                  period_in  = cmd_in.period_ms;
                  handler_in = cmd_in.handler_present;
                  start_in   = cmd_in.start_now;
                  stamp_in   = now_in;
                  active_in  = 1'b1;
               end
            end
            OP_RESTAMP: begin
               if (hit) begin
                  stamp_in = now_in;
               end
            end
            OP_HALT: begin
               if (hit) begin
                  active_in = 1'b0;
               end
            end
            OP_RESUME: begin
               if (hit && !active_ff) begin
                  active_in = 1'b1;
                  stamp_in  = now_in;
               end
            end
            default: begin
            end
         endcase
      end

      cmd_in_next = cmd_in;
      if (fire) begin
         cmd_in_next.fired_mask = cmd_in.fired_mask | CELL_BIT;
      end
      if (active_in) begin
         cmd_in_next.active_mask = cmd_in.active_mask | CELL_BIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= '0;
         stamp_ff   <= '0;
         active_ff  <= 1'b1;
         start_ff   <= 1'b0;
         handler_ff <= 1'b0;
      end else begin
         period_ff  <= period_in;
         stamp_ff   <= stamp_in;
         active_ff  <= active_in;
         start_ff   <= start_in;
         handler_ff <= handler_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff <= '0;
      end else if (!stall) begin
         cmd_ff <= cmd_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         now_ff <= now_in;
      end
   end

   assign cmd_out = cmd_ff;
   assign now_out = now_ff;

endmodule

### rtl/core/periodic_timer_bank_top.sv
// periodic_timer_bank_top: bank of periodic timers built as a row of timer cells
// depends on ptb_pkg, ptb_req_if, ptb_rsp_if and ptb_cell
//
// usage
//    req carries one command item: scan, begin, restamp, halt or resume, with the
//    current millisecond time. rsp returns exactly one item per command: the mask
//    of timers that fired in a scan, the mask of active timers after the command
//    and an accepted flag that drops for an addressed timer index out of range.
//    an accepted item walks the cell row, visiting one timer per cycle, then lands
//    in the rsp output register, which drives rsp valid. one item is in the row
//    at a time, so a new item is taken only once the previous one has left the
//    row; the row length sets how long that takes. req is ready again while the
//    previous result still waits in the output register. if rsp stalls with the
//    register full, the finished item holds at the end of the row and req stays
//    low until it moves on.
//    reset is synchronous: all periods, stamps, start and handler bits clear, all
//    timers come up active, both channels empty.
`timescale 1ns / 1ps

module periodic_timer_bank_top #(
   parameter int NUM_TIMERS = 8,
   parameter int TIME_BITS  = 32
) (
   input  logic clock,
   input  logic reset,
   ptb_req_if.sink   req,
   ptb_rsp_if.source rsp
);
   import ptb_pkg::*;

   cmd_type              chain [NUM_TIMERS+1];
   logic [TIME_BITS-1:0] now_chain [NUM_TIMERS+1];

   logic              busy_ff, busy_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0] rsp_fired_ff;
   logic [MASK_W-1:0] rsp_active_ff;
   logic              rsp_accepted_ff;

   logic    take;
   logic    stall;
   logic    tail_move;
   logic    addressed;
   cmd_type head;

   always_comb begin
      take      = req.valid && !busy_ff;
      addressed = (req.opcode == OP_BEGIN) || (req.opcode == OP_RESTAMP) ||
                  (req.opcode == OP_HALT) || (req.opcode == OP_RESUME);

      head                 = '0;
      head.valid           = take;
      head.opcode          = req.opcode;
      head.timer_index     = req.timer_index;
      head.period_ms       = req.period_ms;
      head.handler_present = req.handler_present;
      head.start_now       = req.start_now;
      head.accepted        = !(addressed && (req.timer_index >= IDX_W'(NUM_TIMERS)));

      stall     = chain[NUM_TIMERS].valid && rsp_valid_ff && !rsp.ready;
      tail_move = chain[NUM_TIMERS].valid && !stall;

      priority if (take) begin
         busy_in = 1'b1;
      end else if (tail_move) begin
         busy_in = 1'b0;
      end else begin
         busy_in = busy_ff;
      end

      priority if (tail_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign chain[0]     = head;
   assign now_chain[0] = TIME_BITS'(req.now_ms);

   for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
      ptb_cell #(
         .TIME_BITS  (TIME_BITS),
         .CELL_INDEX (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .stall   (stall),
         .cmd_in  (chain[i]),
         .now_in  (now_chain[i]),
         .cmd_out (chain[i+1]),
         .now_out (now_chain[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tail_move) begin
         rsp_fired_ff    <= chain[NUM_TIMERS].fired_mask;
         rsp_active_ff   <= chain[NUM_TIMERS].active_mask;
         rsp_accepted_ff <= chain[NUM_TIMERS].accepted;
      end
   end

   assign req.ready       = !busy_ff;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.fired_mask  = rsp_fired_ff;
   assign rsp.active_mask = rsp_active_ff;
   assign rsp.accepted    = rsp_accepted_ff;

endmodule

### rtl/core/ptb_checker.sv
// ptb_checker: port-level checks of the periodic timer bank, bound to the top
// depends on periodic_timer_bank_top and its channel interfaces
`timescale 1ns / 1ps

module ptb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_fired_mask,
   input logic [7:0] rsp_active_mask,
   input logic       rsp_accepted
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fired_mask) &&
      $stable(rsp_active_mask) && $stable(rsp_accepted))
      else $error("rsp item changed while stalled");

   // only one item walks the cell row
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req taken while an item is in flight");

   // a timer only fires while active
   a_fire_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fired_mask & ~rsp_active_mask) == 8'd0)
      else $error("fired timer not active");

   // a rejected index is never a scan
   a_reject_no_fire: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accepted |-> rsp_fired_mask == 8'd0)
      else $error("fire mask on rejected item");

endmodule

bind periodic_timer_bank_top ptb_checker u_ptb_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_fired_mask  (rsp.fired_mask),
   .rsp_active_mask (rsp.active_mask),
   .rsp_accepted    (rsp.accepted)
);

### tb/ptb_bank_checker.sv
// ptb_bank_checker: watches the command and result channels of the timer bank,
// keeps its own copy of every timer and compares each result item with it
// depends on ptb_pkg, ptb_req_if and ptb_rsp_if
`timescale 1ns / 1ps

module ptb_bank_checker #(
   parameter int NUM_TIMERS = 8
) (
   input  logic clock,
   input  logic reset,
   ptb_req_if   req,
   ptb_rsp_if   rsp,
   output int   mismatches,
   output int   outstanding
);
   import ptb_pkg::*;

   typedef struct packed {
      logic [MASK_W-1:0] fired_mask;
      logic [MASK_W-1:0] active_mask;
      logic              accepted;
   } timer_result_type;

   logic [PERIOD_W-1:0]   periods [NUM_TIMERS];
   logic [NOW_W-1:0]      stamps  [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] running;
   logic [NUM_TIMERS-1:0] kick;
   logic [NUM_TIMERS-1:0] has_handler;
   timer_result_type      results_due[$];
   int                    errors = 0;

   function automatic timer_result_type apply_command(
      input logic [OP_W-1:0]     op,
      input logic [IDX_W-1:0]    idx,
      input logic [NOW_W-1:0]    now,
      input logic [PERIOD_W-1:0] period,
      input logic                handler,
      input logic                start
   );
      timer_result_type res;
      logic [NOW_W-1:0] elapsed;
      res = '0;
      res.accepted = 1'b1;
      if (op == OP_SCAN) begin
         for (int i = 0; i < NUM_TIMERS; i++) begin
            elapsed = now - stamps[i];
            if (periods[i] != '0 && has_handler[i] && running[i] &&
                (elapsed >= periods[i] || kick[i])) begin
               stamps[i] = now;
               kick[i] = 1'b0;
               if (i < MASK_W)
                  res.fired_mask[i] = 1'b1;
            end
         end
      end else if (op <= OP_RESUME) begin
         if (idx >= NUM_TIMERS) begin
            res.accepted = 1'b0;
         end else begin
            case (op)
               OP_BEGIN: begin
                  periods[idx] = period;
                  has_handler[idx] = handler;
                  kick[idx] = start;
                  stamps[idx] = now;
                  running[idx] = 1'b1;
               end
               OP_RESTAMP: stamps[idx] = now;
               OP_HALT: running[idx] = 1'b0;
               default: begin
                  if (!running[idx]) begin
                     running[idx] = 1'b1;
                     stamps[idx] = now;
                  end
               end
            endcase
         end
      end
      for (int i = 0; i < NUM_TIMERS && i < MASK_W; i++)
         res.active_mask[i] = running[i];
      return res;
   endfunction

   always @(posedge clock) begin
      timer_result_type due;
      if (reset) begin
         for (int i = 0; i < NUM_TIMERS; i++) begin
            periods[i] = '0;
            stamps[i] = '0;
         end
         running = '1;
         kick = '0;
         has_handler = '0;
         results_due.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (results_due.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: result item with none expected: fired %h active %h %s %b",
                           $realtime, rsp.fired_mask, rsp.active_mask, "accepted",
                           rsp.accepted);
            end else begin
               due = results_due.pop_front();
               if (rsp.fired_mask !== due.fired_mask ||
                   rsp.active_mask !== due.active_mask ||
                   rsp.accepted !== due.accepted) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: mismatch: expected fired %h active %h accepted %b, %s %h %s %h %s %b",
                              $realtime, due.fired_mask, due.active_mask, due.accepted,
                              "got fired", rsp.fired_mask, "active", rsp.active_mask,
                              "accepted", rsp.accepted);
               end
            end
         end
         if (req.valid && req.ready)
            results_due.push_back(apply_command(req.opcode, req.timer_index, req.now_ms,
                                                req.period_ms, req.handler_present,
                                                req.start_now));
      end
      mismatches <= errors;
      outstanding <= results_due.size();
   end

endmodule

### tb/tb_periodic_timer_bank_top.sv
// tb_periodic_timer_bank_top: drives directed and random commands into the timer bank,
// stalls both channels at random and reports the verdict
// depends on ptb_pkg, ptb_ifs, periodic_timer_bank_top and ptb_bank_checker
`timescale 1ns / 1ps

module tb_periodic_timer_bank_top;
   import ptb_pkg::*;

   localparam int NUM_TIMERS   = 8;
   localparam int QUIET_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 4 * (NUM_TIMERS + 1);

   localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

   logic             clock = 1'b0;
   logic             reset;
   int               mismatches;
   int               outstanding;
   int               quiet_cycles = 0;
   int               send_idle_pct = 0;
   int               take_idle_pct = 0;
   logic [NOW_W-1:0] wall_ms = '0;

   ptb_req_if req();
   ptb_rsp_if rsp();

   periodic_timer_bank_top #(
      .NUM_TIMERS(NUM_TIMERS),
      .TIME_BITS (NOW_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req  (req),
      .rsp  (rsp)
   );

   ptb_bank_checker #(
      .NUM_TIMERS(NUM_TIMERS)
   ) bank_check (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .mismatches (mismatches),
      .outstanding(outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp.ready <= reset ? 1'b0 : ($urandom_range(99) >= take_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_command(
      input logic [OP_W-1:0]     op,
      input logic [IDX_W-1:0]    idx,
      input logic [NOW_W-1:0]    now,
      input logic [PERIOD_W-1:0] period,
      input logic                handler,
      input logic                start
   );
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.opcode <= op;
      req.timer_index <= idx;
      req.now_ms <= now;
      req.period_ms <= period;
      req.handler_present <= handler;
      req.start_now <= start;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic hold_until_drained();
      req.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic run_directed();
      send_command(OP_SCAN, 0, '0, '0, 1'b0, 1'b0);
      send_command(OP_BEGIN, 0, 100, 10, 1'b1, 1'b0);
      send_command(OP_BEGIN, 7, '1, '1, 1'b1, 1'b1);
      send_command(OP_BEGIN, 3, 5, 1, 1'b0, 1'b1);
      send_command(OP_BEGIN, 2, 5, '0, 1'b1, 1'b1);
      send_command(OP_SCAN, 255, 109, '0, 1'b0, 1'b0);
      send_command(OP_SCAN, 0, 110, '1, 1'b1, 1'b1);
      send_command(OP_RESTAMP, 0, 200, '0, 1'b0, 1'b0);
      send_command(OP_SCAN, 0, 205, '0, 1'b0, 1'b0);
      send_command(OP_HALT, 0, 206, '0, 1'b0, 1'b0);
      send_command(OP_SCAN, 0, 400, '0, 1'b0, 1'b0);
      send_command(OP_RESUME, 0, 400, '0, 1'b0, 1'b0);
      send_command(OP_RESUME, 0, 405, '0, 1'b0, 1'b0);
      send_command(OP_SCAN, 0, 410, '0, 1'b0, 1'b0);
      send_command(OP_BEGIN, 8, 0, 5, 1'b1, 1'b1);
      send_command(OP_RESTAMP, 255, 0, '0, 1'b0, 1'b0);
      send_command(OP_HALT, 200, 0, '0, 1'b0, 1'b0);
      send_command(OP_RESUME, 8, 0, '0, 1'b0, 1'b0);
      send_command(OP_SPARE_LO, 1, 500, 7, 1'b1, 1'b1);
      send_command(OP_SPARE_MID, 2, 500, 7, 1'b1, 1'b1);
      send_command(OP_SPARE_HI, 255, 500, '1, 1'b1, 1'b1);
      send_command(OP_BEGIN, 1, 32'hFFFF_FFF8, 16, 1'b1, 1'b0);
      send_command(OP_SCAN, 0, 7, '0, 1'b0, 1'b0);
      send_command(OP_SCAN, 0, 8, '0, 1'b0, 1'b0);
      send_command(OP_HALT, 7, 9, '0, 1'b0, 1'b0);
   endtask

   task automatic run_random(input int count);
      logic [OP_W-1:0]     op;
      logic [IDX_W-1:0]    idx;
      logic [PERIOD_W-1:0] period;
      int                  pick;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 3)
            wall_ms = $urandom;
         else
            wall_ms += $urandom_range(12);
         pick = $urandom_range(99);
         if (pick < 45)
            op = OP_SCAN;
         else if (pick < 62)
            op = OP_BEGIN;
         else if (pick < 73)
            op = OP_RESTAMP;
         else if (pick < 84)
            op = OP_HALT;
         else if (pick < 95)
            op = OP_RESUME;
         else
            op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
         if (op == OP_SCAN || $urandom_range(99) < 10)
            idx = IDX_W'($urandom_range(255));
         else
            idx = IDX_W'($urandom_range(NUM_TIMERS - 1));
         pick = $urandom_range(99);
         if (pick < 70)
            period = PERIOD_W'($urandom_range(1, 40));
         else if (pick < 80)
            period = '0;
         else if (pick < 90)
            period = $urandom;
         else
            period = '1 - $urandom_range(3);
         send_command(op, idx, wall_ms, period, $urandom_range(99) < 85,
                      $urandom_range(99) < 25);
      end
   endtask

   initial begin
      reset <= 1'b1;
      req.valid <= 1'b0;
      req.opcode <= OP_SCAN;
      req.timer_index <= '0;
      req.now_ms <= '0;
      req.period_ms <= '0;
      req.handler_present <= 1'b0;
      req.start_now <= 1'b0;
      send_idle_pct = 6;
      take_idle_pct = 78;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      hold_until_drained();
      run_random(680);
      hold_until_drained();

      send_idle_pct = 78;
      take_idle_pct = 6;
      run_random(650);
      hold_until_drained();

      send_idle_pct = 0;
      take_idle_pct = 0;
      run_random(650);
      hold_until_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
